[hw/rtl/twg_pkg.sv]
// Shared constants, codes and control types of the 104-bit twister generator.
package twg_pkg;

  localparam int unsigned WordW     = 52;
  localparam int unsigned HalfW     = 26;
  localparam int unsigned CfgW      = 64;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned OffW      = 5;
  localparam int unsigned LsbW      = 6;
  localparam int unsigned BshW      = 3;
  localparam int unsigned RshW      = 6;
  localparam int unsigned DefEntries = 32;

  // Seed chain multiplier; only its low 52 bits reach a 52-bit result.
  localparam logic [63:0] SeedMult = 64'd6364136223846793005;
  localparam logic [HalfW-1:0] MulLo = SeedMult[HalfW-1:0];
  localparam logic [HalfW-1:0] MulHi = SeedMult[2*HalfW-1:HalfW];

  // Request opcodes
  localparam logic OpGen  = 1'b0;
  localparam logic OpSeed = 1'b1;

  // Output selection
  localparam logic ModePair     = 1'b0;
  localparam logic ModeStraddle = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPickOffset  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLeftShift   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgByteShift   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRshMasked   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRshPlain    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMaskLow     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMaskHigh    = 3'd6;

  // Configuration reset values
  localparam logic [OffW-1:0] RstPickOffset = 5'd1;
  localparam logic [LsbW-1:0] RstLeftShift  = 6'd11;
  localparam logic [BshW-1:0] RstByteShift  = 3'd7;
  localparam logic [RshW-1:0] RstRshMasked  = 6'd7;
  localparam logic [RshW-1:0] RstRshPlain   = 6'd7;
  localparam logic [CfgW-1:0] RstMaskLow    = 64'd7;
  localparam logic [CfgW-1:0] RstMaskHigh   = 64'd7;

  typedef struct packed {
    logic seed_start;  // load seed, write entry 0 low word
    logic seed_m0;     // low x low partial product plus step count
    logic seed_m1;     // low x high cross term
    logic seed_m2;     // high x low cross term, word done
    logic gen_start;   // read current and offset entries
    logic gen_calc;    // recursion, write back, fetch next low word
    logic out_load;    // capture result pair
  } cmd_t;

  typedef struct packed {
    logic off_ok;      // pick offset is reduced below the table depth
    logic seed_last;   // the word in progress is the last lung word
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

[hw/rtl/twg_if.sv]
// Valid/ready channel interfaces for requests and result pairs.
interface twg_in_if;
  import twg_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic             mode;
  logic [WordW-1:0] seed;
  modport source (output valid, output op, output mode, output seed, input ready);
  modport sink   (input valid, input op, input mode, input seed, output ready);
endinterface

interface twg_out_if;
  import twg_pkg::*;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] first_word;
  logic [WordW-1:0] second_word;
  modport source (output valid, output first_word, output second_word, input ready);
  modport sink   (input valid, input first_word, input second_word, output ready);
endinterface

[hw/rtl/twg_ctrl.sv]
// Sequencer for seed and generate requests.
module twg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_op_i,
  input  twg_pkg::status_t status_i,
  output logic            in_ready_o,
  output twg_pkg::cmd_t   cmd_o
);
  import twg_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StGenCalc = 3'd1;
  localparam logic [2:0] StGenOut  = 3'd2;
  localparam logic [2:0] StSeedM0  = 3'd3;
  localparam logic [2:0] StSeedM1  = 3'd4;
  localparam logic [2:0] StSeedM2  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = status_i.off_ok;
        if (in_valid_i && status_i.off_ok) begin
          if (in_op_i == OpSeed) begin
            cmd_o.seed_start = 1'b1;
            state_d          = StSeedM0;
          end else begin
            cmd_o.gen_start = 1'b1;
            state_d         = StGenCalc;
          end
        end
      end
      StGenCalc: begin
        cmd_o.gen_calc = 1'b1;
        state_d        = StGenOut;
      end
      StGenOut: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      StSeedM0: begin
        cmd_o.seed_m0 = 1'b1;
        state_d       = StSeedM1;
      end
      StSeedM1: begin
        cmd_o.seed_m1 = 1'b1;
        state_d       = StSeedM2;
      end
      StSeedM2: begin
        cmd_o.seed_m2 = 1'b1;
        state_d       = status_i.seed_last ? StIdle : StSeedM0;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/twg_datapath.sv]
// Table memories, seed multiplier, recursion logic and output register.
module twg_datapath #(
  parameter int unsigned ENTRIES = twg_pkg::DefEntries
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [twg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [twg_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        in_mode_i,
  input  logic [twg_pkg::WordW-1:0]   in_seed_i,
  input  twg_pkg::cmd_t               cmd_i,
  output twg_pkg::status_t            status_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [twg_pkg::WordW-1:0]   first_word_o,
  output logic [twg_pkg::WordW-1:0]   second_word_o
);
  import twg_pkg::*;

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CmpW = ((OffW > IdxW) ? OffW : IdxW) + 1;
  localparam int unsigned KW   = $clog2(2 * ENTRIES + 2);
  localparam int unsigned PadW = CfgW - WordW;

  // ---------------- configuration ----------------
  logic [OffW-1:0] off_q;
  logic [LsbW-1:0] lsb_q;
  logic [BshW-1:0] bsh_q;
  logic [RshW-1:0] rsm_q, rsp_q;
  logic [CfgW-1:0] mlo_q, mhi_q;
  logic            off_big;

  // Offset is reduced modulo depth, one subtraction per write-free cycle.
  assign off_big = CmpW'(off_q) >= CmpW'(ENTRIES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= RstPickOffset;
      lsb_q <= RstLeftShift;
      bsh_q <= RstByteShift;
      rsm_q <= RstRshMasked;
      rsp_q <= RstRshPlain;
      mlo_q <= RstMaskLow;
      mhi_q <= RstMaskHigh;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPickOffset: off_q <= cfg_wdata_i[OffW-1:0];
        CfgLeftShift:  lsb_q <= cfg_wdata_i[LsbW-1:0];
        CfgByteShift:  bsh_q <= cfg_wdata_i[BshW-1:0];
        CfgRshMasked:  rsm_q <= cfg_wdata_i[RshW-1:0];
        CfgRshPlain:   rsp_q <= cfg_wdata_i[RshW-1:0];
        CfgMaskLow:    mlo_q <= cfg_wdata_i;
        CfgMaskHigh:   mhi_q <= cfg_wdata_i;
        default: ;
      endcase
    end else if (off_big) begin
      off_q <= OffW'(CmpW'(off_q) - CmpW'(ENTRIES));
    end
  end

  // ---------------- index arithmetic ----------------
  logic [IdxW-1:0] idx_q, p_idx, b_idx;
  logic [CmpW-1:0] bsum, bred;

  assign p_idx = (idx_q == IdxW'(ENTRIES - 1)) ? '0 : idx_q + 1'b1;
  assign bsum  = CmpW'(idx_q) + CmpW'(off_q);
  assign bred  = (bsum >= CmpW'(ENTRIES)) ? bsum - CmpW'(ENTRIES) : bsum;
  assign b_idx = bred[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.seed_start) begin
      idx_q <= '0;
    end else if (cmd_i.gen_calc) begin
      idx_q <= p_idx;
    end
  end

  // ---------------- seed chain ----------------
  logic [WordW-1:0] w_q, acc_q, w_new, prod;
  logic [HalfW-1:0] mul_a, mul_b;
  logic [KW-1:0]    k_q;
  logic             k_in_table;

  assign mul_a = cmd_i.seed_m2 ? w_q[WordW-1:HalfW] : w_q[HalfW-1:0];
  assign mul_b = cmd_i.seed_m1 ? MulHi : MulLo;
  assign prod  = WordW'(mul_a) * WordW'(mul_b);
  assign w_new = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
  assign k_in_table = k_q < KW'(2 * ENTRIES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.seed_start) begin
      k_q <= KW'(1);
    end else if (cmd_i.seed_m2) begin
      k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_start) begin
      w_q <= in_seed_i;
    end else if (cmd_i.seed_m2) begin
      w_q <= w_new;
    end
    if (cmd_i.seed_m0) begin
      acc_q <= prod + WordW'(k_q);
    end else if (cmd_i.seed_m1) begin
      acc_q <= w_new;
    end
  end

  // ---------------- recursion ----------------
  logic [WordW-1:0] lo_rd0_q, lo_rd1_q, hi_rd0_q, hi_rd1_q;
  logic [WordW-1:0] prev_lo_q, prev_hi_q, lung_lo_q, lung_hi_q;
  logic [WordW-1:0] r0, r1;
  logic [2*CfgW-1:0] xa;
  logic [CfgW-1:0]  alo, ahi, blo, bhi, clo, chi, cpl, r0w, r1w;

  assign alo = {{PadW{1'b0}}, lo_rd0_q};
  assign ahi = {{PadW{1'b0}}, hi_rd0_q};
  assign blo = {{PadW{1'b0}}, lo_rd1_q};
  assign bhi = {{PadW{1'b0}}, hi_rd1_q};
  assign clo = {{PadW{1'b0}}, prev_lo_q};
  assign chi = {{PadW{1'b0}}, prev_hi_q};
  assign xa  = {ahi, alo} << {bsh_q, 3'b000};
  assign cpl = clo >> rsp_q;
  assign r0w = alo ^ xa[CfgW-1:0] ^ ((blo >> rsm_q) & mlo_q) ^ (clo << lsb_q) ^ cpl
             ^ {{PadW{1'b0}}, lung_hi_q};
  assign r1w = ahi ^ xa[2*CfgW-1:CfgW] ^ ((bhi >> rsm_q) & mhi_q) ^ (chi << lsb_q) ^ cpl
             ^ {{PadW{1'b0}}, lung_lo_q};
  assign r0  = r0w[WordW-1:0];
  assign r1  = r1w[WordW-1:0];

  // c operand is always the most recently written entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_start) begin
      prev_lo_q <= in_seed_i;
    end else if (cmd_i.seed_m2 && k_in_table && !k_q[0]) begin
      prev_lo_q <= w_new;
    end else if (cmd_i.gen_calc) begin
      prev_lo_q <= r0;
    end
    if (cmd_i.seed_m2 && k_in_table && k_q[0]) begin
      prev_hi_q <= w_new;
    end else if (cmd_i.gen_calc) begin
      prev_hi_q <= r1;
    end
    if (cmd_i.seed_m2 && k_q == KW'(2 * ENTRIES)) begin
      lung_lo_q <= w_new;
    end else if (cmd_i.gen_calc) begin
      lung_lo_q <= lung_lo_q ^ r0;
    end
    if (cmd_i.seed_m2 && k_q == KW'(2 * ENTRIES + 1)) begin
      lung_hi_q <= w_new;
    end else if (cmd_i.gen_calc) begin
      lung_hi_q <= lung_hi_q ^ r1;
    end
  end

  // ---------------- table memories ----------------
  logic [WordW-1:0] lo_mem [ENTRIES];
  logic [WordW-1:0] hi_mem [ENTRIES];
  logic             lo_we, hi_we;
  logic [IdxW-1:0]  lo_wa, hi_wa, lo_ra1;
  logic [WordW-1:0] lo_wd, hi_wd;

  assign lo_we = cmd_i.seed_start || cmd_i.gen_calc || (cmd_i.seed_m2 && k_in_table && !k_q[0]);
  assign hi_we = cmd_i.gen_calc || (cmd_i.seed_m2 && k_in_table && k_q[0]);
  assign lo_wa = cmd_i.seed_start ? '0 : (cmd_i.seed_m2 ? k_q[IdxW:1] : idx_q);
  assign hi_wa = cmd_i.seed_m2 ? k_q[IdxW:1] : idx_q;
  assign lo_wd = cmd_i.seed_start ? in_seed_i : (cmd_i.seed_m2 ? w_new : r0);
  assign hi_wd = cmd_i.seed_m2 ? w_new : r1;
  // second low port fetches the offset entry, then the next entry's low word
  assign lo_ra1 = cmd_i.gen_start ? b_idx : p_idx;

  always_ff @(posedge clk_i) begin
    if (lo_we) begin
      lo_mem[lo_wa] <= lo_wd;
    end
    if (cmd_i.gen_start) begin
      lo_rd0_q <= lo_mem[idx_q];
    end
    if (cmd_i.gen_start || cmd_i.gen_calc) begin
      lo_rd1_q <= lo_mem[lo_ra1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hi_we) begin
      hi_mem[hi_wa] <= hi_wd;
    end
    if (cmd_i.gen_start) begin
      hi_rd0_q <= hi_mem[idx_q];
      hi_rd1_q <= hi_mem[b_idx];
    end
  end

  // ---------------- output register ----------------
  logic             mode_q, out_valid_q;
  logic [WordW-1:0] first_q, second_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.gen_start) begin
      mode_q <= in_mode_i;
    end
    if (cmd_i.out_load) begin
      first_q  <= (mode_q == ModeStraddle) ? hi_rd0_q : lo_rd0_q;
      second_q <= (mode_q == ModeStraddle) ? lo_rd1_q : hi_rd0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign first_word_o  = first_q;
  assign second_word_o = second_q;

  assign status_o.off_ok    = !off_big;
  assign status_o.seed_last = k_q == KW'(2 * ENTRIES + 1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

[hw/rtl/parametrized_104bit_twister_generator.sv]
// Top level of the 104-bit twister generator: controller plus datapath.
//
// Usage
//   in_i  : request channel (valid/ready). op selects generate or seed; mode
//           selects the output pair of a generate; seed is used by a seed.
//   out_o : result channel (valid/ready), one pair per generate request,
//           nothing for a seed request.
//   cfg_* : write-only register port, taken whenever cfg_we_i is high.
// Sequencing
//   Generate: accept, recursion, then result load, which waits for a free
//   output register. The two table memories have two read ports each; the
//   current and offset entries are read at acceptance, the next entry's low
//   word during the recursion. Seed: 2*ENTRIES+1 chain words follow the
//   seed word, each taking three passes through the shared 26x26 multiplier.
//   After a pick_offset write, in_i.ready stays low while the offset is
//   reduced modulo ENTRIES.
// Reset clears the state machine, entry index and output valid and presets
//   config registers; the table and lung hold garbage until the first seed.
// A stalled receiver leaves the result in the output register; a following
//   generate runs its recursion and then waits to load its own result.
module parametrized_104bit_twister_generator #(
  parameter int unsigned ENTRIES = twg_pkg::DefEntries
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [twg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [twg_pkg::CfgW-1:0]    cfg_wdata_i,
  twg_in_if.sink                      in_i,
  twg_out_if.source                   out_o
);
  import twg_pkg::*;

  cmd_t    cmd;
  status_t status;

  twg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .status_i   (status),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  twg_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_mode_i     (in_i.mode),
    .in_seed_i     (in_i.seed),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .first_word_o  (out_o.first_word),
    .second_word_o (out_o.second_word)
  );

endmodule

[sim/parametrized_104bit_twister_generator_tb.sv]
// Self-checking testbench of the 104-bit twister generator: random requests against a predictor.
module parametrized_104bit_twister_generator_tb;
  import twg_pkg::*;

  localparam int unsigned Entries      = DefEntries;
  // A seed runs 3 multiplier passes per chain word; an offset write adds a
  // short reduction. Wait this long after the last result before touching
  // the registers or ending the run.
  localparam int unsigned SettleCycles = 3 * (2 * Entries + 1) + 1 + 24;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned RandPerPhase = 212;
  localparam int unsigned CycleLimit   = 1_500_000;
  localparam logic [63:0] ChainMult    = 64'd6364136223846793005;
  localparam logic [63:0] WordMask     = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [WordW-1:0] AllOnes = '1;

  typedef struct packed {
    logic             op;
    logic             mode;
    logic [WordW-1:0] seed;
    logic [4:0]       gap;    // idle cycles before this request is offered
  } twister_req_t;

  typedef struct packed {
    logic [WordW-1:0] first_word;
    logic [WordW-1:0] second_word;
  } word_pair_t;

  typedef struct packed {
    logic [OffW-1:0] pick_off;
    logic [LsbW-1:0] lsh;
    logic [BshW-1:0] bsh;
    logic [RshW-1:0] rsh_masked;
    logic [RshW-1:0] rsh_plain;
    logic [CfgW-1:0] mask_lo;
    logic [CfgW-1:0] mask_hi;
  } twister_cfg_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;

  twg_in_if  in_if ();
  twg_out_if out_if ();

  parametrized_104bit_twister_generator #(
    .ENTRIES (Entries)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predictor state: shadow registers plus our own copy of the table.
  twister_cfg_t      settings;
  logic [WordW-1:0]  lo_words [Entries];
  logic [WordW-1:0]  hi_words [Entries];
  logic [WordW-1:0]  lung_lo;
  logic [WordW-1:0]  lung_hi;
  int unsigned       cur_entry;

  twister_req_t      pending_reqs [$];
  word_pair_t        expected_pairs [$];
  twister_req_t      next_req;
  word_pair_t        got_pair;
  word_pair_t        want_pair;

  logic              in_took;    // request accepted at the last rising edge
  logic              out_took;   // result accepted at the last rising edge
  bit                in_calm;    // stretch with no gaps between requests
  bit                out_calm;   // stretch with no receiver stalls
  int unsigned       out_stall;
  int unsigned       mismatches;
  int unsigned       cycle_count;

  // One step of the seeding chain, kept at 52 bits.
  function automatic logic [63:0] chain_next(input logic [63:0] w, input int unsigned k);
    return (ChainMult * (w ^ (w >> 62)) + 64'(k)) & WordMask;
  endfunction

  function automatic void reseed_table(input logic [WordW-1:0] s);
    logic [63:0] w;
    w = 64'(s);
    for (int unsigned j = 0; j < Entries; j++) begin
      if (j != 0) w = chain_next(w, 2 * j);
      lo_words[j] = w[WordW-1:0];
      w = chain_next(w, 2 * j + 1);
      hi_words[j] = w[WordW-1:0];
    end
    w = chain_next(w, 2 * Entries);
    lung_lo = w[WordW-1:0];
    w = chain_next(w, 2 * Entries + 1);
    lung_hi = w[WordW-1:0];
    cur_entry = 0;
  endfunction

  // Recursion on entry i. All terms are formed at 64 bits and only then
  // cut to 52, so left shifts may carry bits past bit 51 before the cut.
  function automatic void advance_entry(input int unsigned i);
    int unsigned  bi;
    int unsigned  ci;
    logic [63:0]  alo, ahi, blo, bhi, clo, chi, r0, r1;
    logic [127:0] x;
    bi  = (i + int'(settings.pick_off)) % Entries;
    ci  = (i + Entries - 1) % Entries;
    alo = 64'(lo_words[i]);
    ahi = 64'(hi_words[i]);
    blo = 64'(lo_words[bi]);
    bhi = 64'(hi_words[bi]);
    clo = 64'(lo_words[ci]);
    chi = 64'(hi_words[ci]);
    x   = {ahi, alo} << {settings.bsh, 3'b000};
    r0  = alo ^ x[63:0] ^ ((blo >> settings.rsh_masked) & settings.mask_lo)
        ^ (clo << settings.lsh) ^ (clo >> settings.rsh_plain) ^ 64'(lung_hi);
    r1  = ahi ^ x[127:64] ^ ((bhi >> settings.rsh_masked) & settings.mask_hi)
        ^ (chi << settings.lsh) ^ (clo >> settings.rsh_plain) ^ 64'(lung_lo);
    lo_words[i] = r0[WordW-1:0];
    hi_words[i] = r1[WordW-1:0];
    lung_lo     = lung_lo ^ r0[WordW-1:0];
    lung_hi     = lung_hi ^ r1[WordW-1:0];
  endfunction

  // Update the predictor for one accepted request; a generate leaves its
  // pair on the expected queue, a seed leaves nothing.
  function automatic void predict_request(input logic op, input logic mode,
                                          input logic [WordW-1:0] s);
    int unsigned i;
    int unsigned nxt;
    word_pair_t  p;
    if (op == OpSeed) begin
      reseed_table(s);
    end else begin
      i   = cur_entry % Entries;
      nxt = (i + 1) % Entries;
      if (mode == ModePair) begin
        p.first_word  = lo_words[i];
        p.second_word = hi_words[i];
      end else begin
        // straddling pair: high word of this entry, low word of the next
        p.first_word  = hi_words[i];
        p.second_word = lo_words[nxt];
      end
      expected_pairs.push_back(p);
      advance_entry(i);
      cur_entry = nxt;
    end
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Seed values lean on the extremes now and then.
  function automatic logic [WordW-1:0] rand_seed();
    logic [63:0] r;
    r = rand64();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return AllOnes;
      default: return r[WordW-1:0];
    endcase
  endfunction

  function automatic twister_cfg_t rand_settings();
    twister_cfg_t c;
    c.pick_off   = OffW'($urandom_range(0, 31));
    c.lsh        = LsbW'($urandom_range(0, 63));
    c.bsh        = BshW'($urandom_range(0, 7));
    c.rsh_masked = RshW'($urandom_range(0, 63));
    c.rsh_plain  = RshW'($urandom_range(0, 63));
    c.mask_lo    = rand64();
    c.mask_hi    = rand64();
    return c;
  endfunction

  // Queue one request with its own leading gap. Calm stretches give
  // back-to-back requests; otherwise the gap is random.
  task automatic queue_req(input logic op, input logic mode, input logic [WordW-1:0] s);
    twister_req_t r;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    r.op   = op;
    r.mode = mode;
    r.seed = s;
    r.gap  = in_calm ? 5'd0 : 5'($urandom_range(0, 19));
    pending_reqs.push_back(r);
  endtask

  // Mostly generates with a reseed now and then; the seed field is random
  // on generates too, where it must be ignored.
  task automatic queue_random(input int unsigned n);
    logic op;
    repeat (n) begin
      op = ($urandom_range(0, 23) == 0) ? OpSeed : OpGen;
      queue_req(op, 1'($urandom_range(0, 1)), rand_seed());
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
  endtask

  task automatic apply_settings(input twister_cfg_t c);
    write_reg(CfgPickOffset, CfgW'(c.pick_off));
    write_reg(CfgLeftShift,  CfgW'(c.lsh));
    write_reg(CfgByteShift,  CfgW'(c.bsh));
    write_reg(CfgRshMasked,  CfgW'(c.rsh_masked));
    write_reg(CfgRshPlain,   CfgW'(c.rsh_plain));
    write_reg(CfgMaskLow,    c.mask_lo);
    write_reg(CfgMaskHigh,   c.mask_hi);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings = c;
  endtask

  // Idle means: every request handed over, no pair outstanding, and a
  // seed that produced no pair has had time to finish.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_if.valid || expected_pairs.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Request driver: offers the head of the queue at the falling edge once
  // the previous request has been taken and its gap has run out.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (pending_reqs.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (pending_reqs[0].gap != 0) begin
        pending_reqs[0].gap = pending_reqs[0].gap - 5'd1;
        in_if.valid <= 1'b0;
      end else begin
        next_req = pending_reqs.pop_front();
        in_if.valid <= 1'b1;
        in_if.op    <= next_req.op;
        in_if.mode  <= next_req.mode;
        in_if.seed  <= next_req.seed;
      end
    end
  end

  // Receiver: draws a fresh stall after every accepted pair.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_took) begin
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 19);
      end
      if (out_stall != 0) begin
        out_stall = out_stall - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: check the result first (it belongs to an older request),
  // then feed any accepted request to the predictor.
  always @(posedge clk_i) begin
    in_took  <= rst_ni && in_if.valid && in_if.ready;
    out_took <= rst_ni && out_if.valid && out_if.ready;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_pair.first_word  = out_if.first_word;
      got_pair.second_word = out_if.second_word;
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %h %h",
                 $time, got_pair.first_word, got_pair.second_word);
        mismatches++;
      end else begin
        want_pair = expected_pairs.pop_front();
        if (got_pair.first_word !== want_pair.first_word) begin
          $display("%0t: first_word mismatch: expected %h, got %h",
                   $time, want_pair.first_word, got_pair.first_word);
          mismatches++;
        end
        if (got_pair.second_word !== want_pair.second_word) begin
          $display("%0t: second_word mismatch: expected %h, got %h",
                   $time, want_pair.second_word, got_pair.second_word);
          mismatches++;
        end
      end
    end
    if (rst_ni && in_if.valid && in_if.ready)
      predict_request(in_if.op, in_if.mode, in_if.seed);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d requests and %0d results outstanding",
               $time, pending_reqs.size(), expected_pairs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    twister_cfg_t c;
    // known values on every input from time zero
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_if.valid  = 1'b0;
    in_if.op     = OpGen;
    in_if.mode   = ModePair;
    in_if.seed   = '0;
    out_if.ready = 1'b0;
    in_took      = 1'b0;
    out_took     = 1'b0;
    in_calm      = 1'b0;
    out_calm     = 1'b0;
    out_stall    = 0;
    mismatches   = 0;
    cycle_count  = 0;
    cur_entry    = 0;
    lung_lo      = '0;
    lung_hi      = '0;
    settings.pick_off   = RstPickOffset;
    settings.lsh        = RstLeftShift;
    settings.bsh        = RstByteShift;
    settings.rsh_masked = RstRshMasked;
    settings.rsh_plain  = RstRshPlain;
    settings.mask_lo    = RstMaskLow;
    settings.mask_hi    = RstMaskHigh;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset settings. The table is seeded before any
    // generate, since unseeded entries hold garbage.
    queue_req(OpSeed, ModePair, '0);
    queue_req(OpGen, ModePair, '0);
    queue_req(OpGen, ModePair, AllOnes);
    queue_req(OpGen, ModeStraddle, '0);
    queue_req(OpGen, ModeStraddle, AllOnes);
    queue_req(OpSeed, ModeStraddle, AllOnes);   // largest seed
    queue_req(OpGen, ModeStraddle, '0);
    queue_req(OpGen, ModePair, '0);
    queue_req(OpSeed, ModePair, 52'hA_AAAA_AAAA_AAAA);
    queue_req(OpGen, ModePair, '0);
    queue_req(OpSeed, ModeStraddle, 52'h5_5555_5555_5555);
    queue_req(OpGen, ModeStraddle, '0);
    queue_req(OpGen, ModePair, '0);
    // back-to-back seeds: only the second one counts
    queue_req(OpSeed, ModePair, 52'h1);
    queue_req(OpSeed, ModePair, 52'h8_0000_0000_0000);
    queue_req(OpGen, ModePair, '0);
    queue_random(RandPerPhase);
    wait_idle();

    // Later phases change the settings between bursts of random requests;
    // the table carries over, so the state keeps evolving across phases.
    for (int unsigned ph = 1; ph < NumPhases; ph++) begin
      case (ph)
        1: begin
          // zero offset reads the current entry as the masked operand;
          // zero shifts pass operands through unchanged
          c = '0;
        end
        2: begin
          c.pick_off   = '1;
          c.lsh        = '1;
          c.bsh        = '1;
          c.rsh_masked = '1;
          c.rsh_plain  = '1;
          c.mask_lo    = '1;
          c.mask_hi    = '1;
        end
        3: begin
          c = rand_settings();
          c.pick_off = '0;
          c.bsh      = '0;
          c.mask_lo  = '1;
          c.mask_hi  = '1;
        end
        4: begin
          // smallest nonzero shifts and offset
          c = rand_settings();
          c.pick_off   = OffW'(1);
          c.lsh        = LsbW'(1);
          c.bsh        = BshW'(1);
          c.rsh_masked = RshW'(1);
          c.rsh_plain  = RshW'(1);
        end
        default: c = rand_settings();
      endcase
      apply_settings(c);
      queue_random(RandPerPhase);
      wait_idle();
    end

    if (expected_pairs.size() != 0) begin
      $display("%0t: %0d results never arrived: expected %h %h, got none", $time,
               expected_pairs.size(), expected_pairs[0].first_word,
               expected_pairs[0].second_word);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/twg_pkg.sv
hw/rtl/twg_if.sv
hw/rtl/twg_ctrl.sv
hw/rtl/twg_datapath.sv
hw/rtl/parametrized_104bit_twister_generator.sv
sim/parametrized_104bit_twister_generator_tb.sv
